// File: hdl/gab_pkg.sv
// Shared types, constants and a helper function for the glyph alpha blend pipeline.
package gab_pkg;

	localparam int unsigned DIM_W       = 13;
	localparam int unsigned MAX_DIM_DEF = 4096;
	localparam int unsigned IDX_W       = 24;
	localparam int unsigned COORD_W     = 12;

	localparam logic [7:0]  KEY_VALUE   = 8'd2;
	localparam logic [7:0]  DEN_COV     = 8'd100;
	localparam logic [7:0]  DEN_ALPHA   = 8'd255;
	localparam logic [12:0] RECIP_100   = 13'd5243;

	localparam logic [31:0]      TEXT_COLOR_RST = 32'hFFFF_FFFF;
	localparam logic [DIM_W-1:0] WIDTH_RST      = 13'd1024;
	localparam logic [DIM_W-1:0] HEIGHT_RST     = 13'd768;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_TEXT_COLOR   = 2'd0;
	localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd1;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd2;

	typedef struct packed {
		logic [31:0]      text_color;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} gab_cfg_t;

	typedef struct packed {
		logic               wr;
		logic [6:0]         cov;
		logic [7:0]         back_r;
		logic [7:0]         back_g;
		logic [7:0]         back_b;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} gab_pix_t;

	typedef struct packed {
		logic             wr;
		logic             den255;
		logic [15:0]      sum_r;
		logic [15:0]      sum_g;
		logic [15:0]      sum_b;
		logic [IDX_W-1:0] index;
	} gab_sum_t;

	// Coverage in percent, floor(gr * 100 / 255), with the divide by 255 done by shift and add.
	function automatic logic [6:0] cov_pct(input logic [7:0] gr);
		logic [15:0] x;
		logic [15:0] t;
		x = 16'(gr) * 16'd100;
		t = x + 16'd1 + (x >> 8);
		return 7'(t[15:8]);
	endfunction

endpackage

// File: hdl/gab_front.sv
// First pipeline stage: clip window, colour key test and coverage lookup.
module gab_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  gab_pkg::gab_cfg_t       cfg,
	input  logic [7:0]              glyph_blue,
	input  logic [7:0]              glyph_green,
	input  logic [7:0]              glyph_red,
	input  logic [7:0]              back_red,
	input  logic [7:0]              back_green,
	input  logic [7:0]              back_blue,
	input  logic [11:0]             pixel_col,
	input  logic [11:0]             pixel_row,
	output logic                    valid_s1,
	output gab_pkg::gab_pix_t       pix_s1
);
	import gab_pkg::*;

	logic in_clip;
	logic keyed;

	assign in_clip = (pixel_col != '0) && (pixel_row != '0)
		&& ({1'b0, pixel_col} < cfg.width) && ({1'b0, pixel_row} < cfg.height);
	assign keyed = (glyph_blue == KEY_VALUE) && (glyph_green == KEY_VALUE)
		&& (glyph_red == KEY_VALUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1.wr     <= in_clip && !keyed;
			pix_s1.cov    <= cov_pct(glyph_red);
			pix_s1.back_r <= back_red;
			pix_s1.back_g <= back_green;
			pix_s1.back_b <= back_blue;
			pix_s1.col    <= pixel_col;
			pix_s1.row    <= pixel_row;
		end
	end

endmodule

// File: hdl/gab_mix.sv
// Second and third pipeline stages: weight selection, channel products and pixel index.
module gab_mix (
	input  logic              clk,
	input  logic              arst_n,
	input  gab_pkg::gab_cfg_t cfg,
	input  logic              valid_s1,
	input  gab_pkg::gab_pix_t pix_s1,
	output logic              valid_s3,
	output gab_pkg::gab_sum_t sum_s3
);
	import gab_pkg::*;

	logic [7:0]         alpha;
	logic               use_cov;
	logic [7:0]         num;
	logic [7:0]         den;

	logic               valid_s2;
	logic               wr_s2;
	logic               den255_s2;
	logic [7:0]         num_s2;
	logic [7:0]         dnum_s2;
	logic [7:0]         back_r_s2;
	logic [7:0]         back_g_s2;
	logic [7:0]         back_b_s2;
	logic [COORD_W-1:0] col_s2;
	logic [IDX_W-1:0]   idx_s2;

	assign alpha   = cfg.text_color[31:24];
	assign use_cov = (pix_s1.cov != '0)
		&& ((15'(pix_s1.cov) * 15'd255) < (15'(alpha) * 15'd100));
	assign num     = use_cov ? {1'b0, pix_s1.cov} : alpha;
	assign den     = use_cov ? DEN_COV : DEN_ALPHA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		wr_s2     <= pix_s1.wr;
		den255_s2 <= !use_cov;
		num_s2    <= num;
		dnum_s2   <= den - num;
		back_r_s2 <= pix_s1.back_r;
		back_g_s2 <= pix_s1.back_g;
		back_b_s2 <= pix_s1.back_b;
		col_s2    <= pix_s1.col;
		idx_s2    <= IDX_W'(25'(pix_s1.row) * 25'(cfg.width));
	end

	always_ff @(posedge clk) begin
		sum_s3.wr     <= wr_s2;
		sum_s3.den255 <= den255_s2;
		sum_s3.sum_r  <= 16'(num_s2) * 16'(cfg.text_color[23:16])
			+ 16'(dnum_s2) * 16'(back_r_s2);
		sum_s3.sum_g  <= 16'(num_s2) * 16'(cfg.text_color[15:8])
			+ 16'(dnum_s2) * 16'(back_g_s2);
		sum_s3.sum_b  <= 16'(num_s2) * 16'(cfg.text_color[7:0])
			+ 16'(dnum_s2) * 16'(back_b_s2);
		sum_s3.index  <= idx_s2 + IDX_W'(col_s2);
	end

endmodule

// File: hdl/gab_norm.sv
// Last pipeline stage: division by the weight denominator and the result register.
module gab_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s3,
	input  gab_pkg::gab_sum_t sum_s3,
	output logic              done,
	output logic              write_enable,
	output logic [23:0]       pixel_index,
	output logic [7:0]        out_red,
	output logic [7:0]        out_green,
	output logic [7:0]        out_blue
);
	import gab_pkg::*;

	// Exact floor division by 255 or by 100 for sums no larger than 255 times the denominator.
	function automatic logic [7:0] div_den(input logic [15:0] s, input logic d255);
		logic [15:0] t;
		logic [28:0] m;
		t = s + 16'd1 + (s >> 8);
		m = 29'(s) * 29'(RECIP_100);
		return d255 ? t[15:8] : m[26:19];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		write_enable <= sum_s3.wr;
		pixel_index  <= sum_s3.wr ? sum_s3.index : '0;
		out_red      <= sum_s3.wr ? div_den(sum_s3.sum_r, sum_s3.den255) : '0;
		out_green    <= sum_s3.wr ? div_den(sum_s3.sum_g, sum_s3.den255) : '0;
		out_blue     <= sum_s3.wr ? div_den(sum_s3.sum_b, sum_s3.den255) : '0;
	end

`ifndef NO_ASSERTIONS
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !write_enable |-> (pixel_index == '0) && (out_red == '0)
			&& (out_green == '0) && (out_blue == '0))
		else $error("Suppressed pixel carries non-zero fields.");

	a_write_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && sum_s3.wr |=> done && write_enable)
		else $error("Write flag lost at the result register.");
`endif

endmodule

// File: hdl/glyph_alpha_blend_pixel_top.sv
// Top level of the glyph alpha blend pipeline with its configuration registers.
// A transferred pixel passes through the s1, s2, s3 and result registers before its result is transferred.
// Throughput: one pixel per clock cycle; four register stages, busy is never raised.
// The result strobe done lasts one cycle and the receiver cannot stall it.
// Reset clears the pipeline valid bits and restores the configuration registers.
module glyph_alpha_blend_pixel_top #(
	parameter int unsigned MAX_DIM = gab_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  glyph_blue,
	input  logic [7:0]  glyph_green,
	input  logic [7:0]  glyph_red,
	input  logic [7:0]  back_red,
	input  logic [7:0]  back_green,
	input  logic [7:0]  back_blue,
	input  logic [11:0] pixel_col,
	input  logic [11:0] pixel_row,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic        write_enable,
	output logic [23:0] pixel_index,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue
);
	import gab_pkg::*;

	localparam int unsigned DIM_MAX_REG = (2 ** DIM_W) - 1;
	localparam int unsigned DIM_CAP_INT = (MAX_DIM > DIM_MAX_REG) ? DIM_MAX_REG : MAX_DIM;
	localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_INT);

	logic [31:0]      text_color_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	gab_cfg_t         cfg;
	logic             accept;
	logic             valid_s1;
	gab_pix_t         pix_s1;
	logic             valid_s3;
	gab_sum_t         sum_s3;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= TEXT_COLOR_RST;
			width_q      <= WIDTH_RST;
			height_q     <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEXT_COLOR: begin
					text_color_q <= cfg_data;
				end
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[DIM_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.text_color = text_color_q;
	assign cfg.width      = (width_q > DIM_CAP) ? DIM_CAP : width_q;
	assign cfg.height     = (height_q > DIM_CAP) ? DIM_CAP : height_q;

	gab_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cfg         (cfg),
		.glyph_blue  (glyph_blue),
		.glyph_green (glyph_green),
		.glyph_red   (glyph_red),
		.back_red    (back_red),
		.back_green  (back_green),
		.back_blue   (back_blue),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.valid_s1    (valid_s1),
		.pix_s1      (pix_s1)
	);

	gab_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.pix_s1   (pix_s1),
		.valid_s3 (valid_s3),
		.sum_s3   (sum_s3)
	);

	gab_norm u_norm (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s3     (valid_s3),
		.sum_s3       (sum_s3),
		.done         (done),
		.write_enable (write_enable),
		.pixel_index  (pixel_index),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue)
	);

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("Transferred pixel did not produce a result after four cycles.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("Result strobe without a matching input transfer.");

	a_clip_edge: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((pixel_col == '0) || (pixel_row == '0)) |-> ##4 !write_enable)
		else $error("Pixel on column or row zero was written.");
`endif

endmodule

// File: sim/glyph_blend_checker.sv
// Checker for the glyph alpha blend pixel block: follows every transfer, predicts and compares.
module glyph_blend_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [7:0]        glyph_blue,
	input  logic [7:0]        glyph_green,
	input  logic [7:0]        glyph_red,
	input  logic [7:0]        back_red,
	input  logic [7:0]        back_green,
	input  logic [7:0]        back_blue,
	input  logic [11:0]       pixel_col,
	input  logic [11:0]       pixel_row,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  gab_pkg::reg_idx_t cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic              done,
	input  logic              write_enable,
	input  logic [23:0]       pixel_index,
	input  logic [7:0]        out_red,
	input  logic [7:0]        out_green,
	input  logic [7:0]        out_blue,
	output int                fail_count,
	output int                pending,
	output int                checked,
	output int                written
);
	timeunit 1ns;
	timeprecision 1ps;

	import gab_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic        we;
		logic [23:0] idx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} blend_t;

	logic [31:0]      text_color;
	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	blend_t           blend_q[$];

	function automatic logic [7:0] mix(input int unsigned num, den, fg, bg);
		return 8'((num * fg + (den - num) * bg) / den);
	endfunction

	function automatic blend_t blend_pixel(input logic [7:0] gb, gg, gr, br, bg, bb,
			input logic [11:0] col, row);
		blend_t      res;
		int unsigned w, h, a, p, num, den;
		res = '0;
		w = (img_w > MAX_DIM_DEF) ? MAX_DIM_DEF : img_w;
		h = (img_h > MAX_DIM_DEF) ? MAX_DIM_DEF : img_h;
		if (col == 0 || row == 0 || col >= w || row >= h)
			return res;
		if (gb == KEY_VALUE && gg == KEY_VALUE && gr == KEY_VALUE)
			return res;
		a = text_color[31:24];
		p = gr;
		p = p * DEN_COV / DEN_ALPHA;
		if (p > 0 && p * DEN_ALPHA < a * DEN_COV) begin
			num = p;
			den = DEN_COV;
		end else begin
			num = a;
			den = DEN_ALPHA;
		end
		res.we = 1'b1;
		res.idx = 24'(row * w + col);
		res.red = mix(num, den, text_color[23:16], br);
		res.green = mix(num, den, text_color[15:8], bg);
		res.blue = mix(num, den, text_color[7:0], bb);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		blend_t got;
		blend_t exp_res;
		if (!arst_n) begin
			text_color = TEXT_COLOR_RST;
			img_w = WIDTH_RST;
			img_h = HEIGHT_RST;
			blend_q.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			written = 0;
		end else begin
			if (done) begin
				got = {write_enable, pixel_index, out_red, out_green, out_blue};
				if (blend_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result with nothing outstanding: we=%0b idx=%0d rgb=%0d,%0d,%0d",
							$realtime, got.we, got.idx, got.red, got.green, got.blue);
				end else begin
					exp_res = blend_q.pop_front();
					checked++;
					if (exp_res.we)
						written++;
					if (got.we !== exp_res.we || got.idx !== exp_res.idx ||
							got.red !== exp_res.red || got.green !== exp_res.green ||
							got.blue !== exp_res.blue) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: mismatch, expected we=%0b idx=%0d rgb=%0d,%0d,%0d %s",
								$realtime, exp_res.we, exp_res.idx, exp_res.red,
								exp_res.green, exp_res.blue,
								$sformatf("got we=%0b idx=%0d rgb=%0d,%0d,%0d", got.we,
									got.idx, got.red, got.green, got.blue));
					end
				end
			end
			if (start && !busy)
				blend_q.push_back(blend_pixel(glyph_blue, glyph_green, glyph_red, back_red,
					back_green, back_blue, pixel_col, pixel_row));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEXT_COLOR: text_color = cfg_data;
					REG_IMAGE_WIDTH: img_w = cfg_data[DIM_W-1:0];
					REG_IMAGE_HEIGHT: img_h = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			pending = blend_q.size();
		end
	end

endmodule

// File: sim/glyph_alpha_blend_pixel_top_test.sv
// Testbench top for the glyph alpha blend pixel block: stimulus, register settings and verdict.
module glyph_alpha_blend_pixel_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gab_pkg::*;

	localparam int N_PHASES        = 10;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int DRAIN_CYCLES    = 8;
	localparam reg_idx_t REG_SPARE = 2'd3;

	typedef struct {
		logic [7:0]  gb;
		logic [7:0]  gg;
		logic [7:0]  gr;
		logic [7:0]  br;
		logic [7:0]  bg;
		logic [7:0]  bb;
		logic [11:0] col;
		logic [11:0] row;
	} pixel_in_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  glyph_blue;
	logic [7:0]  glyph_green;
	logic [7:0]  glyph_red;
	logic [7:0]  back_red;
	logic [7:0]  back_green;
	logic [7:0]  back_blue;
	logic [11:0] pixel_col;
	logic [11:0] pixel_row;
	logic        cfg_valid;
	logic        cfg_ready;
	reg_idx_t    cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	logic        write_enable;
	logic [23:0] pixel_index;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;

	int          fail_count;
	int          pending;
	int          checked;
	int          written;
	int          quiet;
	int unsigned idle_pct;
	int unsigned cur_w;
	int unsigned cur_h;

	glyph_alpha_blend_pixel_top dut (.*);

	glyph_blend_checker blend_check (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
					WATCHDOG_LIMIT, pending);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic pixel_in_t mk_pixel(input logic [7:0] gb, gg, gr, br, bg, bb,
			input logic [11:0] col, row);
		pixel_in_t px;
		px.gb = gb;
		px.gg = gg;
		px.gr = gr;
		px.br = br;
		px.bg = bg;
		px.bb = bb;
		px.col = col;
		px.row = row;
		return px;
	endfunction

	function automatic pixel_in_t random_pixel();
		pixel_in_t   px;
		int unsigned sel;
		int unsigned wlim;
		int unsigned hlim;
		px.gb = 8'($urandom);
		px.gg = 8'($urandom);
		px.gr = 8'($urandom);
		px.br = 8'($urandom);
		px.bg = 8'($urandom);
		px.bb = 8'($urandom);
		sel = $urandom_range(99);
		if (sel < 14) begin
			px.gb = KEY_VALUE;
			px.gg = KEY_VALUE;
			px.gr = KEY_VALUE;
			if (sel >= 8) begin
				case ($urandom_range(2))
					0: px.gb = 8'($urandom);
					1: px.gg = 8'($urandom);
					default: px.gr = 8'($urandom);
				endcase
			end
		end else if (sel < 22) begin
			px.gr = 8'd0;
		end else if (sel < 30) begin
			px.gr = 8'hFF;
		end
		wlim = (cur_w > 4095) ? 4095 : cur_w;
		hlim = (cur_h > 4095) ? 4095 : cur_h;
		sel = $urandom_range(99);
		if (sel < 25) begin
			px.col = 12'($urandom);
			px.row = 12'($urandom);
		end else begin
			px.col = 12'($urandom_range(wlim));
			px.row = 12'($urandom_range(hlim));
			if (sel < 35 && cur_w > 0)
				px.col = 12'(cur_w - 1);
			else if (sel < 45 && cur_h > 0)
				px.row = 12'(cur_h - 1);
		end
		return px;
	endfunction

	task automatic send_pixel(input pixel_in_t px);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		glyph_blue <= px.gb;
		glyph_green <= px.gg;
		glyph_red <= px.gr;
		back_red <= px.br;
		back_green <= px.bg;
		back_blue <= px.bb;
		pixel_col <= px.col;
		pixel_row <= px.row;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			cur_w = (data[12:0] > MAX_DIM_DEF) ? MAX_DIM_DEF : data[12:0];
		else if (idx == REG_IMAGE_HEIGHT)
			cur_h = (data[12:0] > MAX_DIM_DEF) ? MAX_DIM_DEF : data[12:0];
	endtask

	task automatic configure(input logic [31:0] colour, width, height);
		write_reg(REG_TEXT_COLOR, colour);
		write_reg(REG_IMAGE_WIDTH, width);
		write_reg(REG_IMAGE_HEIGHT, height);
	endtask

	initial begin
		logic [31:0] colour;
		logic [31:0] width;
		logic [31:0] height;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		glyph_blue = '0;
		glyph_green = '0;
		glyph_red = '0;
		back_red = '0;
		back_green = '0;
		back_blue = '0;
		pixel_col = '0;
		pixel_row = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEXT_COLOR;
		cfg_data = '0;
		quiet = 0;
		idle_pct = 13;
		cur_w = WIDTH_RST;
		cur_h = HEIGHT_RST;
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_pixel(mk_pixel(8'd10, 8'd20, 8'd128, 8'd40, 8'd50, 8'd60, 12'd0, 12'd5));
		send_pixel(mk_pixel(8'd10, 8'd20, 8'd128, 8'd40, 8'd50, 8'd60, 12'd5, 12'd0));
		send_pixel(mk_pixel(8'd10, 8'd20, 8'd128, 8'd40, 8'd50, 8'd60, 12'd1, 12'd1));
		send_pixel(mk_pixel(8'd10, 8'd20, 8'd200, 8'd40, 8'd50, 8'd60, 12'd1023, 12'd767));
		send_pixel(mk_pixel(8'd10, 8'd20, 8'd200, 8'd40, 8'd50, 8'd60, 12'd1024, 12'd10));
		send_pixel(mk_pixel(8'd10, 8'd20, 8'd200, 8'd40, 8'd50, 8'd60, 12'd10, 12'd768));
		send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF));
		send_pixel(mk_pixel(KEY_VALUE, KEY_VALUE, KEY_VALUE, 8'd9, 8'd9, 8'd9, 12'd7, 12'd7));
		send_pixel(mk_pixel(KEY_VALUE, KEY_VALUE, 8'd3, 8'd9, 8'd9, 8'd9, 12'd7, 12'd8));
		send_pixel(mk_pixel(8'd3, KEY_VALUE, KEY_VALUE, 8'd9, 8'd9, 8'd9, 12'd8, 12'd7));
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 8'd100, 8'd150, 8'd200, 12'd30, 12'd40));
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd255, 8'd100, 8'd150, 8'd200, 12'd31, 12'd40));
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd254, 8'd100, 8'd150, 8'd200, 12'd32, 12'd40));
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd1, 8'd100, 8'd150, 8'd200, 12'd33, 12'd40));
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd3, 8'd100, 8'd150, 8'd200, 12'd34, 12'd40));
		send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0, 12'd100, 12'd200));
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 12'd101, 12'd200));
		wait_idle();
		configure(32'h8040_C020, 32'd1024, 32'd768);
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd128, 8'd77, 8'd88, 8'd99, 12'd500, 12'd300));
		send_pixel(mk_pixel(8'd0, 8'd0, 8'd131, 8'd77, 8'd88, 8'd99, 12'd501, 12'd300));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			colour = $urandom;
			width = $urandom_range(1) ? $urandom_range(64, 1) : $urandom_range(MAX_DIM_DEF, 1);
			height = $urandom_range(1) ? $urandom_range(64, 1) : $urandom_range(MAX_DIM_DEF, 1);
			case (ph)
				1: begin
					colour = 32'h0000_0000;
					width = MAX_DIM_DEF;
					height = MAX_DIM_DEF;
				end
				2: begin
					colour = 32'hFFFF_FFFF;
					width = 1;
					height = 1;
				end
				3: begin
					width = 0;
					height = 300;
				end
				4: begin
					width = ($urandom & 32'hFFFF_E000) | 32'h0000_1FFF;
					height = 32'h0000_1FFF;
				end
				5: begin
					width = 17;
					height = MAX_DIM_DEF;
				end
				6: colour = colour & 32'h00FF_FFFF;
				7: begin
					width = MAX_DIM_DEF;
					height = 2;
				end
				default: ;
			endcase
			wait_idle();
			configure(colour, width, height);
			if (ph == 4)
				write_reg(REG_SPARE, $urandom);
			idle_pct = (ph < 4) ? 13 : (ph < 7) ? 62 : 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i == ITEMS_PER_PHASE / 2)
					wait_idle();
				send_pixel(random_pixel());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		$display("Checked %0d pixels, %0d of them written, over %0d register settings.",
			checked, written, N_PHASES + 2);
		$display("Clip edges, colour key, weight limits, zero alpha and oversize images: %0d failures.",
			fail_count);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
